// File: hdl/timed_task_queue_core_macros.svh
// assertion macros for the timed task queue
`ifndef TIMED_TASK_QUEUE_CORE_MACROS_SVH
`define TIMED_TASK_QUEUE_CORE_MACROS_SVH
`define TTQ_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("label failed");
`define TTQ_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("label failed");
`endif

// File: hdl/ttq_pkg.sv
// shared types and constants of the timed task queue
package ttq_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_OUT = 16;
    localparam int IN_W = 56;
    localparam int OUT_W = 40;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_ADDED = 3'd0,
        KIND_FULL = 3'd1,
        KIND_CANCEL = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_IDLE = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0] action;
        logic [15:0] tag;
        logic [19:0] delay;
        logic [15:0] task_handle;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [15:0] handle_out;
        logic [15:0] tag_out;
        logic [4:0] removed_count;
        logic last;
    } res_t;
endpackage

// File: hdl/ttq_front.sv
// input stage: drops unused codes and holds commands in a two-entry queue
module ttq_front
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  ttq_pkg::cmd_t in_cmd,
    output logic cmd_valid,
    input  logic cmd_ready,
    output ttq_pkg::cmd_t cmd
);
    import ttq_pkg::*;

    cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready && (in_cmd.action != ACT_NONE);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop = cmd_valid && cmd_ready;
    assign cmd = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[rd_reg ^ cnt_reg[0]] <= in_cmd;
    end
endmodule

// File: hdl/ttq_back.sv
// execution engine: sorted insert, cancel compaction and expiry drain
module ttq_back #(
    parameter int CAPACITY = ttq_pkg::CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  ttq_pkg::cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output ttq_pkg::res_t res
);
    import ttq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] now_reg;
    logic [31:0] exp_reg [CAPACITY];
    logic [15:0] tag_reg [CAPACITY];
    logic [15:0] hdl_reg [CAPACITY];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] keep_reg;
    logic [6:0] rem_reg;
    logic [4:0] nout_reg;
    cmd_t cur_reg;
    logic [31:0] nexp_reg;
    res_t res_reg;
    logic [31:0] now_next;
    logic [31:0] d_head;
    logic [31:0] d_prev;
    logic [31:0] d_second;
    logic head_due;
    logic more_due;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res = res_reg;
    assign now_next = now_reg + 32'd1;
    assign d_head = now_reg - exp_reg[0];
    assign head_due = (count_reg != '0) && !d_head[31];
    assign d_prev = exp_reg[idx_reg[IW-1:0] - IW'(1)] - nexp_reg;
    assign d_second = now_reg - exp_reg[1 % CAPACITY];
    // another entry is due after the head leaves and the per-tick limit is not reached
    assign more_due = (count_reg > CW'(1)) && !d_second[31] &&
                      (nout_reg + 5'd1 != 5'(MAX_OUT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            now_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            keep_reg <= '0;
            rem_reg <= '0;
            nout_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg <= cmd;
                        nexp_reg <= now_reg + {12'd0, cmd.delay};
                        idx_reg <= '0;
                        keep_reg <= '0;
                        rem_reg <= '0;
                        nout_reg <= '0;
                        if (cmd.action == ACT_TICK)
                            now_reg <= now_next;
                        if (cmd.action == ACT_ADD && count_reg == CW'(CAPACITY))
                        begin
                            res_reg <= '{KIND_FULL, 16'd0, 16'd0, 5'd0, 1'b1};
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            if (cmd.action == ACT_ADD)
                                idx_reg <= count_reg;
                            state_reg <= S_WORK;
                        end
                    end
                end
                S_WORK:
                begin
                    case (cur_reg.action)
                        ACT_ADD:
                        begin
                            // walk down from the tail, shifting later entries up
                            if (idx_reg != '0 && !d_prev[31])
                            begin
                                exp_reg[idx_reg[IW-1:0]] <=
                                    exp_reg[idx_reg[IW-1:0] - IW'(1)];
                                tag_reg[idx_reg[IW-1:0]] <=
                                    tag_reg[idx_reg[IW-1:0] - IW'(1)];
                                hdl_reg[idx_reg[IW-1:0]] <=
                                    hdl_reg[idx_reg[IW-1:0] - IW'(1)];
                                idx_reg <= idx_reg - CW'(1);
                            end
                            else
                            begin
                                exp_reg[idx_reg[IW-1:0]] <= nexp_reg;
                                tag_reg[idx_reg[IW-1:0]] <= cur_reg.tag;
                                hdl_reg[idx_reg[IW-1:0]] <= cur_reg.task_handle;
                                count_reg <= count_reg + CW'(1);
                                res_reg <= '{KIND_ADDED, 16'd0, 16'd0, 5'd0, 1'b1};
                                state_reg <= S_OUT;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            if (idx_reg != count_reg)
                            begin
                                if (tag_reg[idx_reg[IW-1:0]] == cur_reg.tag)
                                    rem_reg <= rem_reg + 7'd1;
                                else
                                begin
                                    exp_reg[keep_reg[IW-1:0]] <= exp_reg[idx_reg[IW-1:0]];
                                    tag_reg[keep_reg[IW-1:0]] <= tag_reg[idx_reg[IW-1:0]];
                                    hdl_reg[keep_reg[IW-1:0]] <= hdl_reg[idx_reg[IW-1:0]];
                                    keep_reg <= keep_reg + CW'(1);
                                end
                                idx_reg <= idx_reg + CW'(1);
                            end
                            else
                            begin
                                count_reg <= keep_reg;
                                res_reg <= '{KIND_CANCEL, 16'd0, cur_reg.tag,
                                    (rem_reg > 7'd31) ? 5'd31 : rem_reg[4:0], 1'b1};
                                state_reg <= S_OUT;
                            end
                        end
                        default:
                        begin
                            // one expired head per pass, then shift the rest down
                            if (head_due && nout_reg != 5'(MAX_OUT))
                            begin
                                res_reg <= '{KIND_EXPIRED, hdl_reg[0], tag_reg[0], 5'd0,
                                    !more_due};
                                for (int i = 0; i < CAPACITY - 1; i++)
                                begin
                                    exp_reg[i] <= exp_reg[i+1];
                                    tag_reg[i] <= tag_reg[i+1];
                                    hdl_reg[i] <= hdl_reg[i+1];
                                end
                                count_reg <= count_reg - CW'(1);
                                nout_reg <= nout_reg + 5'd1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                res_reg <= '{KIND_IDLE, 16'd0, 16'd0, 5'd0, 1'b1};
                                state_reg <= S_OUT;
                            end
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        if (res_reg.kind == KIND_EXPIRED && !res_reg.last)
                            state_reg <= S_WORK;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/timed_task_queue_core.sv
// top level of the timed task queue
// Sorted timer queue of CAPACITY entries held in registers. Add walks from
// the tail (one tail-to-head shift step per cycle), cancel takes one
// compaction step per entry, a tick drains expired entries one at a time, at
// most MAX_OUT per tick, or reports idle when none is due; the single back-end
// sequencer takes one command at a time and output stalls hold it. Action code
// 3 is dropped. Results wait in a register; a two-beat command queue in front
// lets input beats be taken while the back end is busy.
module timed_task_queue_core #(
    parameter int CAPACITY = ttq_pkg::CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // tag[15:0], delay[35:16], task_handle[51:36]
    input  logic [ttq_pkg::IN_W-1:0] s_tdata,
    // action[1:0]
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // handle_out[15:0], tag_out[31:16], removed_count[36:32]
    output logic [ttq_pkg::OUT_W-1:0] m_tdata,
    // kind[2:0]
    output logic [2:0] m_tuser,
    output logic m_tlast
);
    import ttq_pkg::*;

    cmd_t in_cmd, cmd;
    res_t res;
    logic cmd_valid, cmd_ready;

    assign in_cmd = '{s_tuser, s_tdata[15:0], s_tdata[35:16], s_tdata[51:36]};

    ttq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(in_cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    ttq_back #(.CAPACITY(CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {3'd0, res.removed_count, res.tag_out, res.handle_out};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule

// File: hdl/ttq_checker.sv
// port-level checks of the timed task queue
`include "timed_task_queue_core_macros.svh"
module ttq_checker
(
    input logic clk,
    input logic rst_n,
    input logic m_tvalid,
    input logic m_tready,
    input logic [ttq_pkg::OUT_W-1:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic m_tlast
);
    import ttq_pkg::*;

    `TTQ_ASSERT(a_kind_range, !m_tvalid || m_tuser <= KIND_IDLE)
    `TTQ_ASSERT(a_nonexp_last, !m_tvalid || m_tuser == KIND_EXPIRED || m_tlast)
    `TTQ_ASSERT_IMPL(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
endmodule

bind timed_task_queue_core ttq_checker u_ttq_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// File: verif/tb_top.sv
// testbench for the timed task queue: random and directed add, cancel and tick beats
module tb_top;
    import ttq_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;
    localparam int WATCHDOG = 20000;

    typedef struct {
        kind_t kind;
        logic [15:0] handle;
        logic [15:0] tag;
        logic [4:0] removed;
        logic last;
    } outcome_t;

    class expiry_board;
        logic [31:0] now_ticks;
        logic [31:0] due_at[$];
        logic [15:0] tags[$];
        logic [15:0] handles[$];
        outcome_t pending[$];
        int errors;
        int seen;

        function new();
            now_ticks = 0;
            errors = 0;
            seen = 0;
        endfunction

        function void push(kind_t k, logic [15:0] h, logic [15:0] t, logic [4:0] r,
                           logic l);
            outcome_t o;
            o.kind = k;
            o.handle = h;
            o.tag = t;
            o.removed = r;
            o.last = l;
            pending.push_back(o);
        endfunction

        function void note_command(action_t act, logic [15:0] tg, logic [19:0] dly,
                                   logic [15:0] hd);
            logic [31:0] exp;
            int pos;
            int n;
            int cnt;
            case (act)
                ACT_ADD:
                begin
                    if (due_at.size() >= DEPTH)
                        push(KIND_FULL, 0, 0, 0, 1);
                    else
                    begin
                        exp = now_ticks + dly;
                        pos = due_at.size();
                        for (int i = 0; i < due_at.size(); i++)
                            if (!((due_at[i] - exp) >> 31))
                            begin
                                pos = i;
                                break;
                            end
                        due_at.insert(pos, exp);
                        tags.insert(pos, tg);
                        handles.insert(pos, hd);
                        push(KIND_ADDED, 0, 0, 0, 1);
                    end
                end
                ACT_CANCEL:
                begin
                    cnt = 0;
                    for (int i = due_at.size() - 1; i >= 0; i--)
                        if (tags[i] == tg)
                        begin
                            due_at.delete(i);
                            tags.delete(i);
                            handles.delete(i);
                            cnt++;
                        end
                    push(KIND_CANCEL, 0, tg, cnt[4:0], 1);
                end
                ACT_TICK:
                begin
                    now_ticks = now_ticks + 1;
                    n = 0;
                    while (n < MAX_OUT && due_at.size() > 0
                           && !((now_ticks - due_at[0]) >> 31))
                    begin
                        push(KIND_EXPIRED, handles[0], tags[0], 0, 0);
                        void'(due_at.pop_front());
                        void'(tags.pop_front());
                        void'(handles.pop_front());
                        n++;
                    end
                    if (n == 0)
                        push(KIND_IDLE, 0, 0, 0, 1);
                    else
                        pending[pending.size() - 1].last = 1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [2:0] usr, logic [OUT_W-1:0] data, logic lst);
            outcome_t e;
            seen++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result user=%h data=%h last=%b", $time, usr,
                         data, lst);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (usr !== e.kind || data[15:0] !== e.handle || data[31:16] !== e.tag
                || data[36:32] !== e.removed || lst !== e.last)
            begin
                $display("%0t: mismatch expected kind=%0d handle=%h tag=%h removed=%0d last=%b",
                         $time, e.kind, e.handle, e.tag, e.removed, e.last);
                $display("%0t:          actual kind=%0d handle=%h tag=%h removed=%0d last=%b",
                         $time, usr, data[15:0], data[31:16], data[36:32], lst);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;

    expiry_board board;
    int idle_pct;
    bit hold_off;
    int quiet_cycles = 0;
    logic [15:0] tag_pool[4] = '{16'h0000, 16'hffff, 16'h1234, 16'h00a5};

    timed_task_queue_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    task automatic send_beat(action_t act, logic [15:0] tg, logic [19:0] dly,
                             logic [15:0] hd);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= {4'b0000, hd, dly, tg};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_command(act, tg, dly, hd);
    endtask

    task automatic random_beat();
        int r;
        action_t act;
        logic [19:0] dly;
        r = $urandom_range(99);
        if (r < 45)
            act = ACT_ADD;
        else if (r < 58)
            act = ACT_CANCEL;
        else if (r < 98)
            act = ACT_TICK;
        else
            act = ACT_NONE;
        dly = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(12));
        send_beat(act, ($urandom_range(3) == 0) ? 16'($urandom)
                  : tag_pool[$urandom_range(3)], dly, 16'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata, m_tlast);
        if (rst_n)
            m_tready <= !hold_off && !(idle_pct > 0 && $urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        board = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        hold_off = 0;
        idle_pct = 31;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_beat(ACT_TICK, 0, 0, 0);
        send_beat(ACT_CANCEL, 16'h1234, 0, 0);
        send_beat(ACT_ADD, 16'hffff, 20'hfffff, 16'hffff);
        send_beat(ACT_ADD, 16'h0000, 0, 16'h0000);
        send_beat(ACT_ADD, 16'h1234, 1, 16'haaaa);
        send_beat(ACT_ADD, 16'h1234, 1, 16'h5555);
        send_beat(ACT_NONE, 16'h0f0f, 3, 16'h1111);
        send_beat(ACT_TICK, 0, 0, 0);
        send_beat(ACT_CANCEL, 16'hffff, 0, 0);
        for (int i = 0; i < 17; i++)
            send_beat(ACT_ADD, 16'h00a5, 20'(i % 3), 16'(i));
        send_beat(ACT_TICK, 0, 0, 0);
        send_beat(ACT_TICK, 0, 0, 0);
        send_beat(ACT_CANCEL, 16'h00a5, 0, 0);

        // receiver stalls long while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++)
                send_beat(ACT_ADD, 16'(i), 0, 16'(i + 100));
        join
        send_beat(ACT_TICK, 0, 0, 0);

        for (int i = 0; i < 150; i++)
        begin
            idle_pct = (i >= 60 && i < 110) ? 0 : 31;
            random_beat();
        end
        idle_pct = 31;
        for (int i = 0; i < 40; i++)
            send_beat(ACT_TICK, 0, 0, 0);
        s_tvalid <= 0;

        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d results from adds, cancels, ticks, full queue and a long stall",
                 board.seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
